[sv/bcpr_pkg.sv]
// ============================================================================
// bcpr_pkg: shared types and constants of the battery charge PWM regulator
// Register indexes, reset values, the limits of the charge loop and the
// structs that carry configuration, input words and result words.
// ============================================================================
`default_nettype none

package bcpr_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CURRENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COEFF   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_SECONDS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PWM        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PWM        = 3'd4;

    // Register reset values
    localparam logic [11:0] TARGET_CURRENT_RESET = 12'd400;
    localparam logic [8:0]  FILTER_COEFF_RESET   = 9'd230;
    localparam logic [15:0] STABLE_SECONDS_RESET = 16'd900;
    localparam logic [9:0]  MAX_PWM_RESET        = 10'd512;
    localparam logic [9:0]  MIN_PWM_RESET        = 10'd256;

    // Loop constants
    localparam logic [9:0]         PWM_RESET      = 10'd256;
    localparam logic [11:0]        DEFAULT_TARGET = 12'd400;
    localparam logic signed [14:0] BIG_ERROR      = 15'sd100;
    localparam logic signed [14:0] SMALL_ERROR    = 15'sd50;
    localparam logic signed [11:0] BIG_STEP       = 12'sd10;
    localparam logic signed [11:0] SMALL_STEP     = 12'sd1;
    localparam logic [8:0]         COEFF_ONE      = 9'd256;
    localparam logic [19:0]        STEADY_LIMIT   = 20'd256;
    localparam logic [15:0]        ELAPSED_MAX    = 16'hFFFF;
    localparam logic [1:0]         HISTORY_FULL   = 2'd2;

    // Widths of the stream words
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [11:0] target_current;
        logic [8:0]  filter_coeff;
        logic [15:0] stable_seconds;
        logic [9:0]  max_pwm;
        logic [9:0]  min_pwm;
    } cfg_t;

    typedef struct packed {
        logic               second_tick;
        logic signed [13:0] measured_current_ma;
        logic [11:0]        voltage_sample;
        logic               on_battery;
    } item_t;

    typedef struct packed {
        logic       is_stable;
        logic       drive_enable;
        logic [9:0] pwm_value;
    } result_t;

    typedef struct packed {
        logic        pass;
        logic        running;
        logic [15:0] elapsed;
    } steady_t;

endpackage

`default_nettype wire

[sv/bcpr_cfg_regs.sv]
// ============================================================================
// bcpr_cfg_regs: configuration register file
// Holds the five loop settings; writes to unused indexes are dropped.
// ============================================================================
`default_nettype none

module bcpr_cfg_regs
    import bcpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_CURRENT: cfg_next.target_current = cfg_data[11:0];
                REG_FILTER_COEFF:   cfg_next.filter_coeff   = cfg_data[8:0];
                REG_STABLE_SECONDS: cfg_next.stable_seconds = cfg_data[15:0];
                REG_MAX_PWM:        cfg_next.max_pwm        = cfg_data[9:0];
                REG_MIN_PWM:        cfg_next.min_pwm        = cfg_data[9:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_current <= TARGET_CURRENT_RESET;
            cfg_reg.filter_coeff   <= FILTER_COEFF_RESET;
            cfg_reg.stable_seconds <= STABLE_SECONDS_RESET;
            cfg_reg.max_pwm        <= MAX_PWM_RESET;
            cfg_reg.min_pwm        <= MIN_PWM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/bcpr_core.sv]
// ============================================================================
// bcpr_core: charge loop state and its update logic
// Keeps the weight history, the steady timer and the PWM value, and works out
// one control call per cycle when enabled.
// ============================================================================
`default_nettype none

module bcpr_core
    import bcpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  update,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    output result_t    result
);

    logic [19:0] weight_latest_reg,   weight_latest_next;
    logic [19:0] weight_previous_reg, weight_previous_next;
    logic [1:0]  sample_count_reg,    sample_count_next;
    logic        steady_running_reg,  steady_running_next;
    logic [15:0] steady_elapsed_reg,  steady_elapsed_next;
    logic        record_pending_reg,  record_pending_next;
    logic [9:0]  pwm_low_reg,         pwm_low_next;

    logic [15:0]        elapsed_tick;
    logic               do_record;
    steady_t            check_first;
    steady_t            check_final;
    logic               running_mid;
    logic [15:0]        elapsed_mid;
    logic               record_now;
    logic [8:0]         coeff;
    logic [8:0]         coeff_inv;
    logic [20:0]        sample_part;
    logic [28:0]        weight_part;
    logic [21:0]        filter_sum;
    logic [19:0]        weight_new;
    logic [19:0]        latest_mid;
    logic [19:0]        previous_mid;
    logic [1:0]         count_mid;
    logic signed [14:0] err;
    logic signed [11:0] pwm_step;
    logic signed [11:0] pwm_floor;
    logic signed [11:0] pwm_cap;
    logic [9:0]         pwm_new;

    // Steady test on the two newest weights. It may start or stop the timer.
    function automatic steady_t steady_check(
        input logic [1:0]  count,
        input logic [19:0] latest,
        input logic [19:0] previous,
        input logic        running,
        input logic [15:0] elapsed,
        input logic [15:0] limit
    );
        logic [19:0] diff;
        steady_t     r;
        r.pass    = 1'b0;
        r.running = running;
        r.elapsed = elapsed;
        diff = (latest >= previous) ? (latest - previous) : (previous - latest);
        if (count == HISTORY_FULL)
        begin
            if (diff >= STEADY_LIMIT)
            begin
                r.running = 1'b0;
                r.elapsed = '0;
            end
            else if (!running)
            begin
                r.running = 1'b1;
                r.elapsed = '0;
            end
            else
            begin
                r.pass = (elapsed > limit);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        // Timer advances once per second while running.
        elapsed_tick = (steady_running_reg && item.second_tick &&
                        steady_elapsed_reg != ELAPSED_MAX) ?
                       steady_elapsed_reg + 16'd1 : steady_elapsed_reg;
        do_record   = record_pending_reg || item.second_tick;
        check_first = steady_check(sample_count_reg, weight_latest_reg,
                                   weight_previous_reg, steady_running_reg,
                                   elapsed_tick, cfg.stable_seconds);
        if (do_record)
        begin
            running_mid = check_first.running;
            elapsed_mid = check_first.elapsed;
            record_now  = !check_first.pass;
        end
        else
        begin
            running_mid = steady_running_reg;
            elapsed_mid = elapsed_tick;
            record_now  = 1'b0;
        end

        // Low-pass filter in Q12.8, rounded half up.
        coeff       = (cfg.filter_coeff > COEFF_ONE) ? COEFF_ONE : cfg.filter_coeff;
        coeff_inv   = COEFF_ONE - coeff;
        sample_part = 21'(item.voltage_sample) * 21'(coeff_inv);
        weight_part = 29'(weight_latest_reg) * 29'(coeff) + 29'd128;
        filter_sum  = 22'(sample_part) + 22'(weight_part[28:8]);
        weight_new  = (sample_count_reg == 2'd0) ?
                      {item.voltage_sample, 8'd0} : filter_sum[19:0];

        if (record_now)
        begin
            latest_mid   = weight_new;
            previous_mid = weight_latest_reg;
            count_mid    = (sample_count_reg == HISTORY_FULL) ?
                           HISTORY_FULL : sample_count_reg + 2'd1;
        end
        else
        begin
            latest_mid   = weight_latest_reg;
            previous_mid = weight_previous_reg;
            count_mid    = sample_count_reg;
        end

        check_final = steady_check(count_mid, latest_mid, previous_mid,
                                   running_mid, elapsed_mid, cfg.stable_seconds);

        // PWM step from the current error, then floor and cap.
        err = $signed({3'b000, cfg.target_current})
            - $signed({item.measured_current_ma[13], item.measured_current_ma});
        pwm_step = $signed({2'b00, pwm_low_reg});
        if (err > BIG_ERROR)
            pwm_step = pwm_step - BIG_STEP;
        else if (err < -BIG_ERROR)
            pwm_step = pwm_step + BIG_STEP;
        else if (err > SMALL_ERROR)
            pwm_step = pwm_step - SMALL_STEP;
        else if (err < -SMALL_ERROR)
            pwm_step = pwm_step + SMALL_STEP;
        pwm_floor = (cfg.target_current == DEFAULT_TARGET) ?
                    $signed({2'b00, cfg.min_pwm}) : 12'sd0;
        pwm_cap   = $signed({2'b00, cfg.max_pwm});
        if (pwm_step < pwm_floor)
            pwm_step = pwm_floor;
        if (pwm_step > pwm_cap)
            pwm_step = pwm_cap;
        pwm_new = pwm_step[9:0];

        if (item.on_battery)
        begin
            weight_latest_next   = weight_latest_reg;
            weight_previous_next = weight_previous_reg;
            sample_count_next    = 2'd0;
            steady_running_next  = 1'b0;
            steady_elapsed_next  = '0;
            record_pending_next  = 1'b1;
            pwm_low_next         = pwm_low_reg;
            result.pwm_value     = pwm_low_reg;
            result.drive_enable  = 1'b0;
            result.is_stable     = 1'b0;
        end
        else
        begin
            weight_latest_next   = latest_mid;
            weight_previous_next = previous_mid;
            sample_count_next    = count_mid;
            steady_running_next  = check_final.running;
            steady_elapsed_next  = check_final.elapsed;
            record_pending_next  = 1'b0;
            pwm_low_next         = check_final.pass ? pwm_low_reg : pwm_new;
            result.pwm_value     = pwm_low_next;
            result.drive_enable  = !check_final.pass;
            result.is_stable     = check_final.pass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_latest_reg   <= '0;
            weight_previous_reg <= '0;
            sample_count_reg    <= '0;
            steady_running_reg  <= 1'b0;
            steady_elapsed_reg  <= '0;
            record_pending_reg  <= 1'b1;
            pwm_low_reg         <= PWM_RESET;
        end
        else if (update)
        begin
            weight_latest_reg   <= weight_latest_next;
            weight_previous_reg <= weight_previous_next;
            sample_count_reg    <= sample_count_next;
            steady_running_reg  <= steady_running_next;
            steady_elapsed_reg  <= steady_elapsed_next;
            record_pending_reg  <= record_pending_next;
            pwm_low_reg         <= pwm_low_next;
        end
    end

endmodule

`default_nettype wire

[sv/battery_charge_pwm_regulator_unit.sv]
// ============================================================================
// battery_charge_pwm_regulator_unit: charge current regulator top level
// Stream-in control calls, stream-out PWM settings, plus a register port.
// ============================================================================
// Each input word is one control call of the charger loop and yields exactly
// one result word. The unit takes a new word in every clock cycle unless the
// result side stalls: a word is captured in an input register, and the whole
// update (voltage filter, steady timer, PWM step) runs from that register
// into the result register as the word moves on, so throughput is one word
// per cycle while no stall holds it. The rate is set by the loop state, which
// every call reads and writes once; the result register frees the input side
// while a result waits, and the input register holds its word only while the
// result register is full and not taken. Configuration writes are accepted in
// every cycle and should be made while no word is in flight.
`default_nettype none

module battery_charge_pwm_regulator_unit
    import bcpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Control call words.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [0] on_battery, [12:1] voltage_sample, [26:13] measured_current_ma,
    // [27] second_tick, [31:28] zero.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    // Result words.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [9:0] pwm_value, [10] drive_enable, [11] is_stable, [15:12] zero.
    output logic [OUT_TDATA_W-1:0]      m_tdata,

    // Register writes: 0 target_current, 1 filter_coeff, 2 stable_seconds,
    // 3 max_pwm, 4 min_pwm.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t out_result_reg, out_result_next;
    logic    out_valid_reg, out_valid_next;
    result_t core_result;
    logic    s_accept;
    logic    advance;

    bcpr_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The core updates its loop state only when the word in the input
    // register moves on into the result register.
    bcpr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .cfg    (cfg),
        .item   (in_item_reg),
        .result (core_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_item_next.on_battery          = s_tdata[0];
            in_item_next.voltage_sample      = s_tdata[12:1];
            in_item_next.measured_current_ma = $signed(s_tdata[26:13]);
            in_item_next.second_tick         = s_tdata[27];
            in_valid_next                    = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_result_next = out_result_reg;
        out_valid_next  = out_valid_reg;
        if (advance)
        begin
            out_result_next = core_result;
            out_valid_next  = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_result_reg.is_stable, out_result_reg.drive_enable,
                       out_result_reg.pwm_value};

endmodule

`default_nettype wire

[tb/tb_battery_charge_pwm_regulator_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_battery_charge_pwm_regulator_unit: self-checking bench of the charge loop
// Sends control-call words through the input stream and checks each result
// word against a behavioral model of the loop kept inside the bench. Directed
// tests cover the error thresholds, the PWM floor and cap, the battery clear
// and the stop on steady voltage. Randomized charge sessions follow under
// changing register settings, with idle cycles and stalls on both streams.
// ============================================================================

module tb_battery_charge_pwm_regulator_unit;
    import bcpr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_WORDS   = 94;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the unit. Every input starts at a known
    // value so the unit never sees an X, even while reset is held.
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    battery_charge_pwm_regulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow of the loop. The register copy follows every accepted write; the
    // state copy follows every accepted control call.
    // ------------------------------------------------------------------------
    cfg_t        loop_cfg;
    logic [19:0] weight_new_q;      // latest filtered voltage, unsigned Q12.8
    logic [19:0] weight_old_q;      // the one before it
    logic [1:0]  weights_held;      // saturates once both entries are valid
    bit          timer_on;
    logic [15:0] timer_secs;
    bit          first_call_due;    // a weight is taken on the next mains call
    logic [9:0]  pwm_now;

    result_t     charge_results_due[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          steady_flow    = 1'b0;    // suppresses idling on both sides

    // The steady test. It also starts and stops the steady timer, so calling
    // it has side effects, just as in the loop itself.
    function automatic bit voltage_settled();
        logic [19:0] delta;
        if (weights_held < HISTORY_FULL)
            return 1'b0;
        delta = (weight_new_q >= weight_old_q) ? weight_new_q - weight_old_q
                                               : weight_old_q - weight_new_q;
        if (delta >= STEADY_LIMIT)
        begin
            timer_on   = 1'b0;
            timer_secs = '0;
            return 1'b0;
        end
        if (!timer_on)
        begin
            timer_on   = 1'b1;
            timer_secs = '0;
            return 1'b0;
        end
        return timer_secs > loop_cfg.stable_seconds;
    endfunction

    // Low-pass filter: the previous weight counts with coeff/256, the new
    // sample with the rest, rounded half up. A coefficient above one acts as
    // exactly one, which freezes the history.
    function automatic void filter_voltage(logic [11:0] sample);
        logic [8:0]  coeff;
        logic [39:0] acc;
        logic [19:0] weight;
        coeff = (loop_cfg.filter_coeff > COEFF_ONE) ? COEFF_ONE : loop_cfg.filter_coeff;
        if (weights_held == 2'd0)
            weight = {sample, 8'd0};
        else
        begin
            acc = 40'(sample) * 40'd256 * 40'(COEFF_ONE - coeff)
                + 40'(weight_new_q) * 40'(coeff) + 40'd128;
            weight = acc[27:8];
        end
        weight_old_q = weight_new_q;
        weight_new_q = weight;
        if (weights_held < HISTORY_FULL)
            weights_held = weights_held + 2'd1;
    endfunction

    function automatic void step_pwm_low(logic signed [13:0] current);
        int err;
        int next_pwm;
        err      = int'(loop_cfg.target_current) - int'(current);
        next_pwm = int'(pwm_now);
        if (err > int'(BIG_ERROR))
            next_pwm -= int'(BIG_STEP);
        else if (err < -int'(BIG_ERROR))
            next_pwm += int'(BIG_STEP);
        else if (err > int'(SMALL_ERROR))
            next_pwm -= int'(SMALL_STEP);
        else if (err < -int'(SMALL_ERROR))
            next_pwm += int'(SMALL_STEP);
        // The floor depends on the target; the cap is applied last and wins.
        if (loop_cfg.target_current == DEFAULT_TARGET)
        begin
            if (next_pwm < int'(loop_cfg.min_pwm))
                next_pwm = int'(loop_cfg.min_pwm);
        end
        else if (next_pwm < 0)
            next_pwm = 0;
        if (next_pwm > int'(loop_cfg.max_pwm))
            next_pwm = int'(loop_cfg.max_pwm);
        pwm_now = next_pwm[9:0];
    endfunction

    // One control call of the loop: updates the shadow state and returns
    // the result word the unit must produce for it.
    function automatic result_t charge_call_result(item_t call);
        result_t res;
        bit      settled;
        bit      drive;
        settled = 1'b0;
        drive   = 1'b0;
        if (call.on_battery)
        begin
            // Running from battery drops the history and the steady timer.
            first_call_due = 1'b1;
            timer_on       = 1'b0;
            timer_secs     = '0;
            weights_held   = '0;
        end
        else
        begin
            if (timer_on && call.second_tick && timer_secs < ELAPSED_MAX)
                timer_secs = timer_secs + 16'd1;
            if (first_call_due || call.second_tick)
            begin
                first_call_due = 1'b0;
                if (!voltage_settled())
                    filter_voltage(call.voltage_sample);
            end
            settled = voltage_settled();
            if (!settled)
            begin
                step_pwm_low(call.measured_current_ma);
                drive = 1'b1;
            end
        end
        res.pwm_value    = pwm_now;
        res.drive_enable = drive;
        res.is_stable    = settled;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers. Every task returns right after a rising
    // edge, so the next one may assign at once without a second nonblocking
    // write to the same signal in one time step. Ready is sampled on the
    // falling edge, where it is settled; the word moves at the next rising
    // edge.
    // ------------------------------------------------------------------------
    task automatic send_call(bit battery, int volts, int current, bit tick);
        item_t call;
        call.on_battery          = battery;
        call.voltage_sample      = volts[11:0];
        call.measured_current_ma = current[13:0];
        call.second_tick         = tick;
        while (!steady_flow && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, call};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        charge_results_due.push_back(charge_call_result(call));
    endtask

    // Stops the input stream and waits until every result is back, then lets
    // the two-stage pipeline go quiet.
    task automatic drain_calls();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (charge_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        case (index)
            REG_TARGET_CURRENT: loop_cfg.target_current = value[11:0];
            REG_FILTER_COEFF:   loop_cfg.filter_coeff   = value[8:0];
            REG_STABLE_SECONDS: loop_cfg.stable_seconds = value;
            REG_MAX_PWM:        loop_cfg.max_pwm        = value[9:0];
            REG_MIN_PWM:        loop_cfg.min_pwm        = value[9:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The result side stalls by chance, about six times in a hundred, unless steady_flow is set.
    always @(posedge clk)
    begin
        m_tready <= steady_flow || ($urandom_range(99) >= 6);
    end

    // ------------------------------------------------------------------------
    // Result checker. A word seen with valid and ready on a falling edge is
    // taken at the next rising edge; it is compared on the falling edge after that,
    // when the expectation of a call accepted at that same rising edge is
    // already queued.
    // ------------------------------------------------------------------------
    bit                     word_taken = 1'b0;
    logic [OUT_TDATA_W-1:0] taken_word;

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(logic [OUT_TDATA_W-1:0] word);
        result_t got;
        result_t want;
        got = result_t'(word[$bits(result_t)-1:0]);
        if (charge_results_due.size() == 0)
        begin
            note_mismatch($sformatf("result word %h with no call outstanding", word));
            return;
        end
        want = charge_results_due.pop_front();
        if (got.pwm_value != want.pwm_value)
            note_mismatch($sformatf("pwm_value expected %0d got %0d",
                                    want.pwm_value, got.pwm_value));
        if (got.drive_enable != want.drive_enable)
            note_mismatch($sformatf("drive_enable expected %0d got %0d",
                                    want.drive_enable, got.drive_enable));
        if (got.is_stable != want.is_stable)
            note_mismatch($sformatf("is_stable expected %0d got %0d",
                                    want.is_stable, got.is_stable));
    endtask

    always @(negedge clk)
    begin
        if (word_taken)
            check_result(taken_word);
        word_taken = rst_n && m_tvalid && m_tready;
        taken_word = m_tdata;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[battery_charge_pwm_regulator_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Reset settings: the first call takes a weight without a tick, then the
    // current error walks across both thresholds on each side of the target.
    // The floor at min_pwm holds the PWM up when the error asks for less.
    task automatic test_error_thresholds();
        send_call(1'b0, 4095, 400, 1'b0);      // no error, first weight
        send_call(1'b0, 0, 501, 1'b1);         // error -101: up by ten
        send_call(1'b0, 4095, 500, 1'b1);      // error -100: up by one
        send_call(1'b0, 0, 451, 1'b0);         // error -51: up by one
        send_call(1'b0, 0, 450, 1'b1);         // error -50: hold
        send_call(1'b0, 4095, 349, 1'b0);      // error 51: down by one
        send_call(1'b0, 0, 350, 1'b1);         // error 50: hold
        send_call(1'b0, 0, 300, 1'b0);         // error 100: down by one
        send_call(1'b0, 4095, 299, 1'b1);      // error 101: down to the floor
        send_call(1'b0, 2048, -8192, 1'b0);    // most negative current
        send_call(1'b0, 2048, 8191, 1'b1);     // most positive current
        send_call(1'b1, 4095, 8191, 1'b1);     // on battery: drive off, PWM held
        drain_calls();
    endtask

    // A frozen filter (coefficient above one) keeps the weights equal, so the
    // loop settles after the timer has run one second past a limit of zero.
    // Going to battery clears it, and the next mains call records at once.
    task automatic test_steady_stop();
        write_reg(REG_FILTER_COEFF, 16'd511);
        write_reg(REG_STABLE_SECONDS, 16'd0);
        send_call(1'b0, 1000, 400, 1'b1);
        send_call(1'b0, 1000, 400, 1'b1);
        send_call(1'b0, 1000, 400, 1'b1);      // timer passes the limit
        send_call(1'b0, 3000, 100, 1'b0);      // stays settled, PWM held
        send_call(1'b1, 1000, 400, 1'b0);
        send_call(1'b0, 1000, 400, 1'b0);      // history restarts without a tick
        drain_calls();
    endtask

    // Floor above cap: the cap wins. A target other than the default floors
    // at zero instead. An unknown register index changes nothing.
    task automatic test_pwm_limits();
        write_reg(REG_MAX_PWM, 16'd5);
        write_reg(REG_MIN_PWM, 16'd1023);
        write_reg(REG_TARGET_CURRENT, 16'(DEFAULT_TARGET));
        write_reg(3'd7, 16'hFFFF);
        send_call(1'b0, 0, 400, 1'b0);
        drain_calls();
        write_reg(REG_TARGET_CURRENT, 16'd4000);
        send_call(1'b0, 0, -8192, 1'b1);       // ten below five clamps to zero
        send_call(1'b0, 0, 8191, 1'b1);        // settled: drive off, PWM held at zero
        drain_calls();
        write_reg(REG_MAX_PWM, 16'd1023);
        write_reg(REG_MIN_PWM, 16'd0);
        write_reg(REG_TARGET_CURRENT, 16'd0);
        send_call(1'b0, 0, 8191, 1'b1);
        drain_calls();
    endtask

    // ------------------------------------------------------------------------
    // Random charge sessions. Each phase picks new register values, extremes
    // included, then runs mostly well-formed sessions on mains (a fixed
    // voltage with a little jitter, currents near the target), mixed with
    // fully random words and bursts on battery. One phase runs with no idle
    // cycles on either side.
    // ------------------------------------------------------------------------
    task automatic test_random_sessions();
        int target;
        int coeff;
        int secs;
        int cap;
        int floor_pwm;
        int phase_words;
        int kind;
        int span;
        int base;
        int jitter;
        int tick_pct;
        int volts;
        int current;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(7))
                0, 1, 2, 3: target = DEFAULT_TARGET;
                4:          target = 0;
                5:          target = 4095;
                default:    target = $urandom_range(4095);
            endcase
            case ($urandom_range(7))
                0:       coeff = 0;
                1:       coeff = COEFF_ONE;
                2:       coeff = 511;
                3:       coeff = FILTER_COEFF_RESET;
                default: coeff = $urandom_range(511);
            endcase
            case ($urandom_range(7))
                0:       secs = 65535;
                1:       secs = STABLE_SECONDS_RESET;
                default: secs = $urandom_range(6);
            endcase
            case ($urandom_range(7))
                0:       cap = 0;
                1:       cap = 1023;
                default: cap = $urandom_range(1023);
            endcase
            case ($urandom_range(7))
                0:       floor_pwm = 0;
                1:       floor_pwm = 1023;
                default: floor_pwm = $urandom_range(1023);
            endcase
            // Bits above each register's width are written at random; only
            // the low bits may take effect.
            write_reg(REG_TARGET_CURRENT, {4'($urandom), 12'(target)});
            write_reg(REG_FILTER_COEFF, {7'($urandom), 9'(coeff)});
            write_reg(REG_STABLE_SECONDS, 16'(secs));
            write_reg(REG_MAX_PWM, {6'($urandom), 10'(cap)});
            write_reg(REG_MIN_PWM, {6'($urandom), 10'(floor_pwm)});

            steady_flow = (phase == 3);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                kind = $urandom_range(9);
                if (kind < 7)
                begin
                    span     = $urandom_range(4, 30);
                    base     = $urandom_range(4095);
                    jitter   = $urandom_range(2);
                    tick_pct = $urandom_range(30, 100);
                    for (int i = 0; i < span; i++)
                    begin
                        volts = base + $urandom_range(jitter);
                        if (volts > 4095)
                            volts = 4095;
                        current = int'(loop_cfg.target_current)
                                + $urandom_range(320) - 160;
                        send_call($urandom_range(99) < 3, volts, current,
                                  $urandom_range(99) < tick_pct);
                    end
                    phase_words += span;
                end
                else if (kind < 9)
                begin
                    span = $urandom_range(1, 8);
                    for (int i = 0; i < span; i++)
                        send_call($urandom_range(1), $urandom_range(4095),
                                  int'($urandom_range(16383)) - 8192, $urandom_range(1));
                    phase_words += span;
                end
                else
                begin
                    span = $urandom_range(1, 4);
                    for (int i = 0; i < span; i++)
                        send_call(1'b1, $urandom_range(4095),
                                  int'($urandom_range(16383)) - 8192, $urandom_range(1));
                    phase_words += span;
                end
            end
            drain_calls();
            steady_flow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        loop_cfg.target_current = TARGET_CURRENT_RESET;
        loop_cfg.filter_coeff   = FILTER_COEFF_RESET;
        loop_cfg.stable_seconds = STABLE_SECONDS_RESET;
        loop_cfg.max_pwm        = MAX_PWM_RESET;
        loop_cfg.min_pwm        = MIN_PWM_RESET;
        weight_new_q   = '0;
        weight_old_q   = '0;
        weights_held   = '0;
        timer_on       = 1'b0;
        timer_secs     = '0;
        first_call_due = 1'b1;
        pwm_now        = PWM_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_error_thresholds();
        test_steady_stop();
        test_pwm_limits();
        test_random_sessions();

        if (mismatch_count == 0 && charge_results_due.size() == 0)
            $display("[battery_charge_pwm_regulator_unit] OK");
        else
            $display("[battery_charge_pwm_regulator_unit] ERROR");
        $finish;
    end

endmodule
